@@ rtl/nlc_pkg.sv @@
// Types, codes and helpers shared by the numeric literal converter modules.
package nlc_pkg;

    localparam int VALUE_W = 32;
    localparam int USED_W  = 6;
    localparam int CHAR_W  = 8;
    localparam int FRAC_W  = 16;
    localparam int CNT_W   = 6;
    localparam int CFG_IDX_W = 1;

    // index of the top dividend bit of (fraction << 16); one dividend bit per division step
    localparam logic [CNT_W-1:0] DIV_LAST_BIT = CNT_W'(VALUE_W + FRAC_W - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIN_ZERO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_ONE  = 1'b1;

    localparam logic [CHAR_W-1:0] BIN_ZERO_RESET = 8'h30;
    localparam logic [CHAR_W-1:0] BIN_ONE_RESET  = 8'h31;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA      = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF      = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA      = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h66;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_HEX  = 2'd1,
        MODE_BIN  = 2'd2,
        MODE_DEC  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_SETUP = 2'd1,
        ST_DIV   = 2'd2,
        ST_LOAD  = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic div_init;
        logic div_step;
        logic out_load;
    } nlc_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } nlc_sts_t;

    // hex digit value, invalid digits give zero
    function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (c >= CH_LA && c <= CH_LF) d = c - CH_LA + 8'd10;
        else if (c >= CH_UA && c <= CH_UF) d = c - CH_UA + 8'd10;
        else if (c >= CH_0 && c <= CH_9) d = c - CH_0;
        return d[3:0];
    endfunction

    // x * 10 modulo 2^32
    function automatic logic [VALUE_W-1:0] times_ten(input logic [VALUE_W-1:0] x);
        return {x[VALUE_W-4:0], 3'b000} + {x[VALUE_W-2:0], 1'b0};
    endfunction

endpackage

@@ rtl/nlc_ctrl.sv @@
// Controller: sequences character intake, fraction division and result load.
module nlc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    input  nlc_pkg::nlc_sts_t sts,
    output nlc_pkg::nlc_cmd_t cmd
);
    import nlc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && in_last) state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.div_init = 1'b1;
                state_next   = sts.need_div ? ST_DIV : ST_LOAD;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done) state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

endmodule

@@ rtl/nlc_datapath.sv @@
// Datapath: token accumulators, bit-serial fraction divider, output register.
module nlc_datapath
#(
    parameter int MAX_TOKEN_CHARS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nlc_pkg::nlc_cmd_t                    cmd,
    output nlc_pkg::nlc_sts_t                    sts,
    input  logic [nlc_pkg::CHAR_W-1:0]           char_code,
    input  logic                                 cfg_write,
    input  logic [nlc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nlc_pkg::CHAR_W-1:0]           cfg_data,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [nlc_pkg::VALUE_W-1:0]          number_value,
    output logic [nlc_pkg::USED_W-1:0]           chars_used,
    output logic                                 is_fixed_point
);
    import nlc_pkg::*;

    localparam logic [USED_W-1:0] MAX_USED = USED_W'(MAX_TOKEN_CHARS);

    logic [CHAR_W-1:0]  bin_zero_reg, bin_one_reg;
    mode_t              mode_reg, mode_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] frac_reg, frac_next;
    logic [VALUE_W-1:0] fdiv_reg, fdiv_next;
    logic               frac_ph_reg, frac_ph_next;
    logic               stop_reg, stop_next;
    logic [USED_W-1:0]  used_reg, used_next;

    logic [VALUE_W-1:0] rem_reg, quo_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [USED_W-1:0]  out_used_reg;
    logic               out_fixed_reg;

    logic               do_dec, do_radix, is_digit, radix_stop, bin_bit, div_bit;
    logic [CHAR_W-1:0]  dec_digit;
    logic [CNT_W-1:0]   bit_idx;
    logic [VALUE_W+1:0] trial;
    logic               fixed_now;
    logic [VALUE_W-1:0] result_now;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_zero_reg <= BIN_ZERO_RESET;
            bin_one_reg  <= BIN_ONE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BIN_ZERO: bin_zero_reg <= cfg_data;
                REG_BIN_ONE:  bin_one_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // character intake
    always_comb
    begin
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        frac_next    = frac_reg;
        fdiv_next    = fdiv_reg;
        frac_ph_next = frac_ph_reg;
        stop_next    = stop_reg;
        used_next    = used_reg;
        do_dec       = 1'b0;
        do_radix     = 1'b0;
        is_digit     = (char_code >= CH_0) && (char_code <= CH_9);
        dec_digit    = char_code - CH_0;
        radix_stop   = stop_reg || (char_code == CH_NUL);
        // zero char wins over one char
        bin_bit      = (char_code != bin_zero_reg) && (char_code == bin_one_reg);

        if (cmd.out_load)
        begin
            mode_next    = MODE_IDLE;
            acc_next     = '0;
            frac_next    = '0;
            fdiv_next    = VALUE_W'(1);
            frac_ph_next = 1'b0;
            stop_next    = 1'b0;
            used_next    = '0;
        end
        else if (cmd.accept && (used_reg < MAX_USED))
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (char_code == CH_DOLLAR)
                    begin
                        mode_next = MODE_HEX;
                        used_next = USED_W'(1);
                    end
                    else if (char_code == CH_PERCENT)
                    begin
                        mode_next = MODE_BIN;
                        used_next = USED_W'(1);
                    end
                    else
                    begin
                        mode_next = MODE_DEC;
                        do_dec    = 1'b1;
                    end
                end
                MODE_DEC: do_dec   = 1'b1;
                default:  do_radix = 1'b1;
            endcase

            if (do_dec && !stop_reg)
            begin
                if (is_digit)
                begin
                    if (frac_ph_reg)
                    begin
                        frac_next = times_ten(frac_reg) + VALUE_W'(dec_digit[3:0]);
                        fdiv_next = times_ten(fdiv_reg);
                    end
                    else
                    begin
                        acc_next = times_ten(acc_reg) + VALUE_W'(dec_digit[3:0]);
                    end
                    used_next = used_reg + USED_W'(1);
                end
                else if (char_code == CH_DOT && !frac_ph_reg)
                begin
                    frac_ph_next = 1'b1;
                    used_next    = used_reg + USED_W'(1);
                end
                else
                begin
                    stop_next = 1'b1;
                end
            end

            if (do_radix)
            begin
                stop_next = radix_stop;
                if (!radix_stop)
                begin
                    if (mode_reg == MODE_HEX)
                        acc_next = {acc_reg[VALUE_W-5:0], hex_value(char_code)};
                    else
                        acc_next = {acc_reg[VALUE_W-2:0], bin_bit};
                end
                used_next = used_reg + USED_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            acc_reg     <= '0;
            frac_reg    <= '0;
            fdiv_reg    <= VALUE_W'(1);
            frac_ph_reg <= 1'b0;
            stop_reg    <= 1'b0;
            used_reg    <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            acc_reg     <= acc_next;
            frac_reg    <= frac_next;
            fdiv_reg    <= fdiv_next;
            frac_ph_reg <= frac_ph_next;
            stop_reg    <= stop_next;
            used_reg    <= used_next;
        end
    end

    // restoring divider over (frac << 16), MSB first, one bit per cycle
    always_comb
    begin
        bit_idx = cnt_reg - CNT_W'(FRAC_W);
        div_bit = (cnt_reg >= CNT_W'(FRAC_W)) ? frac_reg[bit_idx[4:0]] : 1'b0;
        trial   = {1'b0, rem_reg, div_bit} - {2'b00, fdiv_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= DIV_LAST_BIT;
        end
        else if (cmd.div_step)
        begin
            // quotient keeps its low 32 bits only
            if (!trial[VALUE_W+1])
            begin
                rem_reg <= trial[VALUE_W-1:0];
                quo_reg <= {quo_reg[VALUE_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[VALUE_W-2:0], div_bit};
                quo_reg <= {quo_reg[VALUE_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // result assembly
    always_comb
    begin
        fixed_now  = (mode_reg == MODE_DEC) && frac_ph_reg;
        result_now = acc_reg;
        if (fixed_now)
            result_now = {acc_reg[FRAC_W-1:0], {FRAC_W{1'b0}}}
                       + (sts.need_div ? quo_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg <= result_now;
            out_used_reg  <= used_reg;
            out_fixed_reg <= fixed_now;
        end
    end

    assign sts.need_div = (mode_reg == MODE_DEC) && frac_ph_reg && (fdiv_reg != '0);
    assign sts.div_done = (cnt_reg == '0);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign number_value   = out_value_reg;
    assign chars_used     = out_used_reg;
    assign is_fixed_point = out_fixed_reg;

endmodule

@@ rtl/numeric_literal_converter.sv @@
// Top level of the numeric literal converter: '$' hex, '%' binary, decimal with 16.16 fraction.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata char_code, tlast last_char
//  m_axis   | out       | m_axis_tvalid/tready    | tdata number_value, chars_used; tuser fixed
//  cfg      | in        | cfg_valid/cfg_ready     | cfg_index register, cfg_data value
//
//  Non-final character requests stream back to back.
//  After the final character: a setup step, then the bit-serial divider (one quotient bit per
//  cycle) when a decimal token has a '.' and a nonzero scale, then a load step that waits
//  until the output register is free.
//  Input is stalled from the final character until the result enters the output register;
//  a result may wait there for m_axis_tready while the next token streams in.
//  Reset (rst_n low, asynchronous) clears the token state and restores the binary digit
//  characters to '0' and '1'. Configuration writes are always taken.
module numeric_literal_converter
#(
    parameter int MAX_TOKEN_CHARS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] number_value, [37:32] chars_used, [39:38] 0
    output logic        m_axis_tuser,   // [0] is_fixed_point
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import nlc_pkg::*;

    nlc_cmd_t           cmd;
    nlc_sts_t           sts;
    logic [VALUE_W-1:0] number_value;
    logic [USED_W-1:0]  chars_used;
    logic               is_fixed_point;

    // configuration registers live in the datapath; no back-pressure
    assign cfg_ready = 1'b1;

    nlc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nlc_datapath #(
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .char_code      (s_axis_tdata),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .number_value   (number_value),
        .chars_used     (chars_used),
        .is_fixed_point (is_fixed_point)
    );

    assign m_axis_tdata = {2'b00, chars_used, number_value};
    assign m_axis_tuser = is_fixed_point;

`ifndef SYNTHESIS
    // divider only runs on a dotted decimal token with nonzero scale
    a_div_needs_fraction: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> sts.need_div)
        else $error("divider stepping without a fraction to scale");

    // a result never overwrites one that has not been taken
    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register loaded while occupied");

    // the final character of a token closes intake for the finishing steps
    a_last_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input accepted while token is finishing");

    // reported count never exceeds the token length limit
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (chars_used <= USED_W'(MAX_TOKEN_CHARS)))
        else $error("chars_used beyond token length limit");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the numeric literal converter: directed and random tokens.
`timescale 1ns / 1ps

module testbench;
    import nlc_pkg::*;

    localparam int TOKEN_LIMIT = 32;
    // drain allowance after the last result: setup, divider and load, with margin
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_CHARS = 225;
    localparam int RANDOM_PHASES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] char_code
    logic        s_axis_tlast = 1'b0; // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [31:0] number_value, [37:32] chars_used, [39:38] 0
    logic        m_axis_tuser;        // [0] is_fixed_point
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    typedef struct {
        logic [31:0] value;
        logic [5:0]  used;
        logic        fixed;
    } literal_result_t;

    // Tracks one token in flight and the results it is owed.
    class literal_checker;
        logic [7:0]  zero_char;
        logic [7:0]  one_char;
        mode_t       mode;
        logic [31:0] whole;
        logic [31:0] frac;
        logic [31:0] scale;
        logic        in_frac;
        logic        stopped;
        logic [5:0]  used;
        literal_result_t pending_values[$];
        int          fails;

        function new();
            zero_char = BIN_ZERO_RESET;
            one_char  = BIN_ONE_RESET;
            fails = 0;
            clear_token();
        endfunction

        function void clear_token();
            mode    = MODE_IDLE;
            whole   = '0;
            frac    = '0;
            scale   = 32'd1;
            in_frac = 1'b0;
            stopped = 1'b0;
            used    = '0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [7:0] val);
            if (idx == REG_BIN_ZERO) zero_char = val;
            else one_char = val;
        endfunction

        function logic [3:0] hex_digit(logic [7:0] c);
            if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h57);
            if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);
            if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
            return 4'd0;
        endfunction

        function logic bin_digit(logic [7:0] c);
            if (c == zero_char) return 1'b0;
            return (c == one_char);
        endfunction

        function void take_decimal(logic [7:0] c);
            logic [31:0] d;
            d = 32'(c) - 32'h30;
            if (stopped) return;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                if (in_frac)
                begin
                    frac  = frac * 32'd10 + d;
                    scale = scale * 32'd10;
                end
                else
                begin
                    whole = whole * 32'd10 + d;
                end
                used++;
            end
            else if (c == CH_DOT && !in_frac)
            begin
                in_frac = 1'b1;
                used++;
            end
            else
            begin
                stopped = 1'b1;
            end
        endfunction

        function void take_radix(logic [7:0] c);
            if (c == CH_NUL) stopped = 1'b1;
            if (!stopped)
            begin
                if (mode == MODE_HEX) whole = {whole[27:0], hex_digit(c)};
                else whole = {whole[30:0], bin_digit(c)};
            end
            used++;
        endfunction

        // Accepted character request: advance the token, queue a result on the last one.
        function void note_char(logic [7:0] c, logic last);
            literal_result_t r;
            logic [63:0] wide;
            logic [31:0] part;
            if (used < 6'(TOKEN_LIMIT))
            begin
                if (mode == MODE_IDLE)
                begin
                    if (c == CH_DOLLAR)
                    begin
                        mode = MODE_HEX;
                        used = 6'd1;
                    end
                    else if (c == CH_PERCENT)
                    begin
                        mode = MODE_BIN;
                        used = 6'd1;
                    end
                    else
                    begin
                        mode = MODE_DEC;
                        take_decimal(c);
                    end
                end
                else if (mode == MODE_DEC)
                begin
                    take_decimal(c);
                end
                else
                begin
                    take_radix(c);
                end
            end
            if (!last) return;
            r.value = whole;
            r.fixed = 1'b0;
            if (mode == MODE_DEC && in_frac)
            begin
                wide = {16'd0, frac, 16'd0};
                part = (scale != 0) ? 32'(wide / {32'd0, scale}) : 32'd0;
                r.value = {whole[15:0], 16'd0} + part;
                r.fixed = 1'b1;
            end
            r.used = used;
            pending_values.push_back(r);
            clear_token();
        endfunction

        function void check_value(logic [39:0] data, logic user);
            literal_result_t r;
            if (pending_values.size() == 0)
            begin
                $display("%0t: unexpected result value=%h used=%0d fixed=%b",
                         $time, data[31:0], data[37:32], user);
                fails++;
                return;
            end
            r = pending_values.pop_front();
            if (data[31:0] !== r.value)
            begin
                $display("%0t: number_value expected %h actual %h", $time, r.value, data[31:0]);
                fails++;
            end
            if (data[37:32] !== r.used)
            begin
                $display("%0t: chars_used expected %0d actual %0d", $time, r.used, data[37:32]);
                fails++;
            end
            if (user !== r.fixed)
            begin
                $display("%0t: is_fixed_point expected %b actual %b", $time, r.fixed, user);
                fails++;
            end
        endfunction

        function int pending();
            return pending_values.size();
        endfunction
    endclass

    literal_checker checker_h = new();

    numeric_literal_converter #(
        .MAX_TOKEN_CHARS (TOKEN_LIMIT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // idle percentages for the current phase
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int chars_sent = 0;
    logic [7:0] tok[$];

    // Result side: sample at the edge, then pick next cycle's stall.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            checker_h.check_value(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // One character request. Valid stays high between back-to-back requests.
    task automatic send_char(input logic [7:0] c, input logic last);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        checker_h.note_char(c, last);
        chars_sent++;
    endtask

    task automatic send_token();
        foreach (tok[i])
            send_char(tok[i], i == tok.size() - 1);
        tok.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            tok.push_back(s[i]);
    endtask

    // Wait out every owed result plus the divider tail before touching registers.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (checker_h.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both digit characters in one burst; valid held high across the pair.
    task automatic write_digits(input logic [7:0] zero_c, input logic [7:0] one_c);
        cfg_valid <= 1'b1;
        cfg_index <= REG_BIN_ZERO;
        cfg_data  <= zero_c;
        do @(posedge clk); while (!cfg_ready);
        checker_h.set_reg(REG_BIN_ZERO, zero_c);
        cfg_index <= REG_BIN_ONE;
        cfg_data  <= one_c;
        do @(posedge clk); while (!cfg_ready);
        checker_h.set_reg(REG_BIN_ONE, one_c);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char();
        int r;
        r = $urandom_range(21);
        if (r < 10) return 8'(8'h30 + r);
        if (r < 16) return 8'(8'h61 + r - 10);
        return 8'(8'h41 + r - 16);
    endfunction

    function automatic int pick_len(input int typical);
        if ($urandom_range(99) < 5) return $urandom_range(40, 28);
        return $urandom_range(typical);
    endfunction

    // Mostly well-formed literals with random content, some junk and raw noise.
    task automatic random_token();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 25)
        begin
            tok.push_back(CH_DOLLAR);
            n = pick_len(10);
            repeat (n)
                tok.push_back(($urandom_range(9) != 0) ? hex_char() : 8'($urandom));
        end
        else if (kind < 45)
        begin
            tok.push_back(CH_PERCENT);
            n = pick_len(16);
            repeat (n)
            begin
                case ($urandom_range(9))
                    0: tok.push_back(8'($urandom));
                    1, 2, 3, 4: tok.push_back(checker_h.zero_char);
                    default: tok.push_back(checker_h.one_char);
                endcase
            end
        end
        else if (kind < 85)
        begin
            n = pick_len(10);
            repeat (n) tok.push_back(8'(8'h30 + $urandom_range(9)));
            if ($urandom_range(9) < 7)
            begin
                tok.push_back(CH_DOT);
                n = pick_len(9);
                repeat (n) tok.push_back(8'(8'h30 + $urandom_range(9)));
            end
            // trailing junk: stray dots or random bytes
            if ($urandom_range(9) < 2)
            begin
                n = $urandom_range(3, 1);
                repeat (n)
                    tok.push_back(($urandom_range(2) == 0) ? CH_DOT : 8'($urandom));
            end
            if (tok.size() == 0) tok.push_back(8'(8'h30 + $urandom_range(9)));
        end
        else
        begin
            n = $urandom_range(6, 1);
            repeat (n) tok.push_back(8'($urandom));
        end
        send_token();
    endtask

    logic [7:0] zero_tab [5] = '{8'h30, 8'h61, 8'h00, 8'hFF, 8'h78};
    logic [7:0] one_tab  [5] = '{8'h31, 8'h62, 8'hFF, 8'h00, 8'h78};

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed tokens under reset digit characters, no idling
        push_text("$");     send_token();   // hex prefix alone
        push_text("%");     send_token();   // binary prefix alone
        push_text("$aFg");  send_token();   // both cases and an invalid hex digit
        push_text("%1x0");  send_token();   // non-digit in binary counts as 0
        push_text("$1");                    // NUL stops hex, later chars still counted
        tok.push_back(CH_NUL);
        push_text("2");     send_token();
        push_text("1.5");   send_token();
        push_text(".25");   send_token();   // dot as first character
        tok.push_back(8'hFF); send_token(); // non-digit first character
        push_text("12.");   send_token();   // dot without fraction digits
        push_text("1.2.");  send_token();   // second dot stops
        push_text("99");    send_token();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // phase boundary: sender holds off until every result is back
            drain();
            if (p != 0) write_digits(zero_tab[p % 5], one_tab[p % 5]);
            case (p % 4)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct = 82;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 82;
                end
                default:
                begin
                    tx_idle_pct = 16;
                    rx_stall_pct = 16;
                end
            endcase
            chars_sent = 0;
            while (chars_sent < PHASE_CHARS) random_token();
        end

        drain();
        if (checker_h.fails == 0 && checker_h.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #12_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ numeric_literal_converter.f @@
rtl/nlc_pkg.sv
rtl/nlc_ctrl.sv
rtl/nlc_datapath.sv
rtl/numeric_literal_converter.sv
tb/testbench.sv
